>>> hdl/ebml_element_header_parser_assert.svh
// ----------------------------------------------------------------------------
// EBML element header parser assertion macros
// Concurrent assertion wrappers, empty when the design is synthesized.
// ----------------------------------------------------------------------------
`ifndef EBML_ELEMENT_HEADER_PARSER_ASSERT_SVH
`define EBML_ELEMENT_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define EHP_ASSERT_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ehp assertion failed");

// Consequence that must hold in the cycle after the antecedent.
`define EHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ehp assertion failed");

`else

`define EHP_ASSERT_ALWAYS(label, clk, rst_n, prop)
`define EHP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/ehp_pkg.sv
// ----------------------------------------------------------------------------
// EBML element header parser package
// Widths, status codes, the parsed header record and the vint length decoder.
// ----------------------------------------------------------------------------
package ehp_pkg;

	// Width of file offsets.
	localparam int OFS_W  = 48;
	localparam int ID_W   = 64;
	localparam int SIZE_W = 56;
	localparam int LEN_W  = 4;
	// Width of the exact end sum (payload start plus size).
	localparam int END_W  = ((OFS_W + 1 > SIZE_W) ? OFS_W + 1 : SIZE_W) + 1;

	// Stream widths.
	localparam int IN_DATA_W   = 8 + 2 * OFS_W;
	localparam int OUT_DATA_W  = ID_W + LEN_W + SIZE_W + LEN_W + 2 * OFS_W;
	localparam int OUT_USER_W  = 3;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	// A completed header as it leaves the byte parser.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [LEN_W-1:0]  id_len;
		logic [SIZE_W-1:0] size;
		logic [LEN_W-1:0]  size_len;
		logic              ones;
		logic [OFS_W-1:0]  offset;
		logic [OFS_W-1:0]  limit;
		logic              invalid;
	} hdr_t;

	// Vint length from its first byte: position of the leading one, 0 if none.
	function automatic logic [LEN_W-1:0] vint_len(input logic [7:0] b);
		logic [LEN_W-1:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				n = LEN_W'(8 - i);
			end
		end
		return n;
	endfunction

endpackage

>>> hdl/ehp_byte_parser.sv
// ----------------------------------------------------------------------------
// EBML header byte parser
// Steps the ID and size vint state one byte per transfer and registers each
// completed or rejected header into the first result stage.
// ----------------------------------------------------------------------------
module ehp_byte_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic              load,
	input  logic [7:0]        data_byte,
	input  logic              header_first,
	input  logic [ehp_pkg::OFS_W-1:0] start_offset,
	input  logic [ehp_pkg::OFS_W-1:0] container_limit,
	output logic              hdr_v_s1,
	output ehp_pkg::hdr_t     hdr_s1
);
	import ehp_pkg::*;

	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_ID       = 2'd1;
	localparam logic [1:0] PH_SZ_FIRST = 2'd2;
	localparam logic [1:0] PH_SZ_REST  = 2'd3;

	logic [1:0]        phase_q, phase_d;
	logic [2:0]        left_q, left_d;
	logic [ID_W-1:0]   id_q, id_d;
	logic [LEN_W-1:0]  id_len_q, id_len_d;
	logic [SIZE_W-1:0] size_q, size_d;
	logic [LEN_W-1:0]  size_len_q, size_len_d;
	logic              ones_q, ones_d;
	logic [OFS_W-1:0]  offset_q, offset_d;
	logic [OFS_W-1:0]  limit_q, limit_d;
	logic [LEN_W-1:0]  blen;
	logic [7:0]        vmask;
	logic              emit;
	hdr_t              ev;

	assign blen  = vint_len(data_byte);
	assign vmask = 8'hFF >> blen;

	// Next parse state and the header record for this byte.
	always_comb begin
		phase_d    = phase_q;
		left_d     = left_q;
		id_d       = id_q;
		id_len_d   = id_len_q;
		size_d     = size_q;
		size_len_d = size_len_q;
		ones_d     = ones_q;
		offset_d   = offset_q;
		limit_d    = limit_q;
		emit       = 1'b0;
		ev         = '0;
		if (header_first) begin
			offset_d = start_offset;
			limit_d  = container_limit;
			if (blen == '0) begin
				phase_d    = PH_IDLE;
				emit       = 1'b1;
				ev.invalid = 1'b1;
			end else begin
				id_d     = ID_W'(data_byte);
				id_len_d = blen;
				left_d   = 3'(blen - LEN_W'(1));
				phase_d  = (blen == LEN_W'(1)) ? PH_SZ_FIRST : PH_ID;
			end
		end else begin
			unique case (phase_q)
				PH_ID: begin
					id_d   = {id_q[ID_W-9:0], data_byte};
					left_d = left_q - 3'd1;
					if (left_q == 3'd1) begin
						phase_d = PH_SZ_FIRST;
					end
				end
				PH_SZ_FIRST: begin
					if (blen == '0) begin
						phase_d    = PH_IDLE;
						emit       = 1'b1;
						ev.id      = id_q;
						ev.id_len  = id_len_q;
						ev.invalid = 1'b1;
					end else begin
						size_len_d = blen;
						size_d     = SIZE_W'(data_byte & vmask);
						ones_d     = ((data_byte & vmask) == vmask);
						left_d     = 3'(blen - LEN_W'(1));
						if (blen == LEN_W'(1)) begin
							phase_d = PH_IDLE;
							emit    = 1'b1;
						end else begin
							phase_d = PH_SZ_REST;
						end
					end
				end
				PH_SZ_REST: begin
					size_d = {size_q[SIZE_W-9:0], data_byte};
					ones_d = ones_q && (data_byte == 8'hFF);
					left_d = left_q - 3'd1;
					if (left_q == 3'd1) begin
						phase_d = PH_IDLE;
						emit    = 1'b1;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
			// A completed size carries the header gathered so far.
			if (emit && !(phase_q == PH_SZ_FIRST && blen == '0)) begin
				ev.id       = id_d;
				ev.id_len   = id_len_d;
				ev.size     = size_d;
				ev.size_len = size_len_d;
				ev.ones     = ones_d;
				ev.offset   = offset_d;
				ev.limit    = limit_d;
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			left_q   <= '0;
			hdr_v_s1 <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				left_q  <= left_d;
			end
			if (load) begin
				hdr_v_s1 <= take && emit;
			end
		end
	end

	// Accumulators and the first result stage.
	always_ff @(posedge clk) begin
		if (take) begin
			id_q       <= id_d;
			id_len_q   <= id_len_d;
			size_q     <= size_d;
			size_len_q <= size_len_d;
			ones_q     <= ones_d;
			offset_q   <= offset_d;
			limit_q    <= limit_d;
		end
		if (load) begin
			hdr_s1 <= ev;
		end
	end

endmodule

>>> hdl/ebml_element_header_parser.sv
// ----------------------------------------------------------------------------
// EBML element header parser
// Parses EBML element ID and size vints from a byte stream and reports the
// header with its payload bounds.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one header byte per transfer. tuser marks the
// first byte of a header; that byte also carries the header's file offset
// and the end offset of its container in tdata. A flagged byte always starts
// a new header and drops any partial one; unflagged bytes outside a header
// are ignored.
// The master stream carries one transfer per finished header: ID, vint
// lengths, size, payload start and end in tdata, size_unknown and status in
// tuser. A zero first byte of either vint gives a result right away with
// status invalid.
// A result is offered after the transfer of the byte that ends its header has
// passed the byte parser stage, start-offset sum, end sum and container check.
// Throughput: one byte per cycle while s_tready is high (single-byte vint step).
// The three result stages move as a pipeline; when the receiver stalls they
// fill up and s_tready falls only once the first stage would be overwritten.
// Reset clears the parse state and empties all stages; no result is pending.
// ----------------------------------------------------------------------------
`include "ebml_element_header_parser_assert.svh"

module ebml_element_header_parser (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// data_byte [7:0], start_offset [55:8], container_limit [103:56]
	input  logic [ehp_pkg::IN_DATA_W-1:0] s_tdata,
	// header_first
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// element_id [63:0], id_bytes [67:64], payload_size [123:68],
	// size_bytes [127:124], payload_start [175:128], element_end [223:176]
	output logic [ehp_pkg::OUT_DATA_W-1:0] m_tdata,
	// size_unknown [0], status [2:1]
	output logic [ehp_pkg::OUT_USER_W-1:0] m_tuser
);
	import ehp_pkg::*;

	logic              en_s1, en_s2, en_out;
	logic              hdr_v_s1;
	hdr_t              hdr_s1;
	logic              v_s2;
	hdr_t              hdr_s2;
	logic [OFS_W:0]    ps_s2;
	logic [END_W-1:0]  end_sum;
	logic [OFS_W-1:0]  end_val;
	logic              big;
	logic [1:0]        st;
	logic [ID_W-1:0]   id_q;
	logic [LEN_W-1:0]  id_len_q;
	logic [SIZE_W-1:0] size_q;
	logic [LEN_W-1:0]  size_len_q;
	logic              unk_q;
	logic [OFS_W-1:0]  ps_q;
	logic [OFS_W-1:0]  end_q;
	logic [1:0]        st_q;

	// Pipeline advance: each stage loads when it is empty or moving on.
	assign en_out   = !m_tvalid || m_tready;
	assign en_s2    = !v_s2 || en_out;
	assign en_s1    = !hdr_v_s1 || en_s2;
	assign s_tready = en_s1;

	ehp_byte_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (s_tvalid && s_tready),
		.load            (en_s1),
		.data_byte       (s_tdata[7:0]),
		.header_first    (s_tuser),
		.start_offset    (s_tdata[8 +: OFS_W]),
		.container_limit (s_tdata[8 + OFS_W +: OFS_W]),
		.hdr_v_s1        (hdr_v_s1),
		.hdr_s1          (hdr_s1)
	);

	// Stage two: exact payload start sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= hdr_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			hdr_s2 <= hdr_s1;
			ps_s2  <= (OFS_W + 1)'(hdr_s1.offset) + (OFS_W + 1)'(hdr_s1.id_len)
				+ (OFS_W + 1)'(hdr_s1.size_len);
		end
	end

	// End offset, range checks and status.
	always_comb begin
		end_sum = END_W'(ps_s2) + END_W'(hdr_s2.size);
		end_val = hdr_s2.ones ? hdr_s2.limit : end_sum[OFS_W-1:0];
		big     = ps_s2[OFS_W] || (!hdr_s2.ones && (end_sum[END_W-1:OFS_W] != '0));
		if (hdr_s2.invalid) begin
			st = ST_INVALID;
		end else if (big || (end_val > hdr_s2.limit)) begin
			st = ST_OVERFLOW;
		end else begin
			st = ST_OK;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en_out) begin
			m_tvalid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			id_q       <= hdr_s2.id;
			id_len_q   <= hdr_s2.id_len;
			size_q     <= hdr_s2.size;
			size_len_q <= hdr_s2.size_len;
			unk_q      <= hdr_s2.ones;
			ps_q       <= hdr_s2.invalid ? '0 : ps_s2[OFS_W-1:0];
			end_q      <= hdr_s2.invalid ? '0 : end_val;
			st_q       <= st;
		end
	end

	assign m_tdata = {end_q, ps_q, size_len_q, size_q, id_len_q, id_q};
	assign m_tuser = {st_q, unk_q};

	// A held first-stage header survives a stall of the stage behind it.
	`EHP_ASSERT_NEXT(a_s1_hold, clk, arst_n, hdr_v_s1 && !en_s2, hdr_v_s1)
	// A good or overflowing header always has both vint lengths.
	`EHP_ASSERT_ALWAYS(a_len_set, clk, arst_n,
		!m_tvalid || st_q == ST_INVALID || (id_len_q != '0 && size_len_q != '0))
	// Rejected headers carry no offsets.
	`EHP_ASSERT_ALWAYS(a_inv_zero, clk, arst_n,
		!m_tvalid || st_q != ST_INVALID || (ps_q == '0 && end_q == '0 && unk_q == 1'b0))
	// An accepted header of known size never ends before its payload starts.
	`EHP_ASSERT_ALWAYS(a_ok_order, clk, arst_n,
		!m_tvalid || st_q != ST_OK || unk_q || end_q >= ps_q)

endmodule
